[hw/rtl/assert_macros.svh]
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg)
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[hw/rtl/kctt_pkg.sv]
// shared types and constants of the keyed countdown timer table
package kctt_pkg;
    localparam int SLOT_COUNT_DEF = 10;
    localparam int KEY_W = 16;
    localparam int MS_W = 26;
    localparam int SEC_W = 16;
    localparam int CNT_W = 4;
    localparam int MS_PER_SEC = 1000;
    localparam int RECIP_SHIFT = 36;
    localparam int RECIP_W = 27;
    localparam logic [RECIP_W-1:0] RECIP = 27'd68719477;
    localparam int PROD_W = MS_W + RECIP_W;

    localparam logic [1:0] FUNC_SET  = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_LIST = 2'd2;
    localparam logic [1:0] FUNC_NOP  = 2'd3;

    localparam logic [1:0] KIND_SET    = 2'd0;
    localparam logic [1:0] KIND_EXPIRY = 2'd1;
    localparam logic [1:0] KIND_LIST   = 2'd2;

    typedef struct packed {
        logic             en;
        logic [KEY_W-1:0] key;
        logic [MS_W-1:0]  ms;
    } mem_wr_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key;
        logic [SEC_W-1:0] secs;
        logic             was;
        logic             bad;
    } res_t;
endpackage

[hw/rtl/kctt_mem.sv]
// slot memory holding key and remaining milliseconds
module kctt_mem
    import kctt_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [IW-1:0]    rd_addr,
    input  logic [IW-1:0]    wr_addr,
    input  mem_wr_t          wr,
    output logic [KEY_W-1:0] rd_key,
    output logic [MS_W-1:0]  rd_ms
);
    logic [KEY_W+MS_W-1:0] mem [SLOT_COUNT];
    logic [KEY_W+MS_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= {wr.key, wr.ms};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_key = rd_data_reg[KEY_W+MS_W-1:MS_W];
    assign rd_ms  = rd_data_reg[MS_W-1:0];
endmodule

[hw/rtl/kctt_ctrl.sv]
// sequencer that scans the slot memory for set, tick and list
module kctt_ctrl
    import kctt_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       func,
    input  logic [KEY_W-1:0] key,
    input  logic [SEC_W-1:0] seconds,
    input  logic [CNT_W-1:0] list_count,
    input  logic             out_free,
    output logic             push,
    output res_t             push_res,
    output logic             push_last
);
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_RD    = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_EVAL  = 7'b0001000,
        ST_SETW  = 7'b0010000,
        ST_PEND  = 7'b0100000,
        ST_FLUSH = 7'b1000000
    } state_t;

    localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

    state_t state_reg, state_next;
    logic [1:0] op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [SEC_W-1:0] secs_reg, secs_next;
    logic [CNT_W-1:0] want_reg, want_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [MS_W-1:0] load_reg, load_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic found_reg, found_next;
    logic [IW-1:0] match_reg, match_next;
    logic best_v_reg, best_v_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic [KEY_W-1:0] best_key_reg, best_key_next;
    logic [SEC_W-1:0] best_q_reg, best_q_next;
    logic [SLOT_COUNT-1:0] taken_reg, taken_next;
    logic [SLOT_COUNT-1:0] running_reg, running_next;
    logic [PROD_W-1:0] prod_reg;
    logic h_valid_reg, h_valid_next;
    res_t h_res_reg, h_res_next;

    logic [KEY_W-1:0] rd_key;
    logic [MS_W-1:0] rd_ms;
    logic rd_en;
    mem_wr_t wr;
    logic [IW-1:0] wr_addr;
    logic can_act, emit;
    res_t emit_res;
    logic [SEC_W-1:0] q;
    logic free_any;
    logic [IW-1:0] free_idx, slot;

    kctt_mem #(.SLOT_COUNT(SLOT_COUNT)) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .wr_addr (wr_addr),
        .wr      (wr),
        .rd_key  (rd_key),
        .rd_ms   (rd_ms)
    );

    assign q = prod_reg[RECIP_SHIFT +: SEC_W];
    assign can_act = !h_valid_reg || out_free;
    assign in_ready = (state_reg == ST_IDLE);
    assign rd_en = (state_reg == ST_RD);

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!running_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
        slot = found_reg ? match_reg : (free_any ? free_idx : '0);
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        key_next = key_reg;
        secs_next = secs_reg;
        want_next = want_reg;
        n_next = n_reg;
        load_next = load_reg;
        idx_next = idx_reg;
        found_next = found_reg;
        match_next = match_reg;
        best_v_next = best_v_reg;
        best_idx_next = best_idx_reg;
        best_key_next = best_key_reg;
        best_q_next = best_q_reg;
        taken_next = taken_reg;
        running_next = running_reg;
        h_valid_next = h_valid_reg;
        h_res_next = h_res_reg;
        emit = 1'b0;
        emit_res = '0;
        wr = '0;
        wr_addr = idx_reg;
        push = 1'b0;
        push_last = 1'b0;
        push_res = h_res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = func;
                    key_next = key;
                    secs_next = seconds;
                    want_next = list_count;
                    load_next = MS_W'({10'd0, seconds} * MS_W'(MS_PER_SEC));
                    idx_next = '0;
                    found_next = 1'b0;
                    best_v_next = 1'b0;
                    n_next = '0;
                    taken_next = '0;
                    if (func == FUNC_SET && key == '0)
                    begin
                        h_valid_next = 1'b1;
                        h_res_next = '{kind: KIND_SET, key: '0, secs: '0, was: 1'b0,
                                       bad: 1'b1};
                        state_next = ST_FLUSH;
                    end
                    else if (func != FUNC_NOP)
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (can_act)
                begin
                    case (op_reg)
                        FUNC_SET:
                        begin
                            if (running_reg[idx_reg] && rd_key == key_reg && !found_reg)
                            begin
                                found_next = 1'b1;
                                match_next = idx_reg;
                            end
                        end
                        FUNC_TICK:
                        begin
                            if (running_reg[idx_reg])
                            begin
                                wr.en = 1'b1;
                                if (rd_ms < MS_W'(2))
                                begin
                                    emit = 1'b1;
                                    emit_res = '{kind: KIND_EXPIRY, key: rd_key, secs: '0,
                                                 was: 1'b0, bad: 1'b0};
                                    running_next[idx_reg] = 1'b0;
                                end
                                else
                                begin
                                    wr.key = rd_key;
                                    wr.ms = rd_ms - MS_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            if (want_reg == '0)
                            begin
                                if (running_reg[idx_reg])
                                begin
                                    emit = 1'b1;
                                    emit_res = '{kind: KIND_LIST, key: rd_key, secs: q,
                                                 was: 1'b0, bad: 1'b0};
                                end
                            end
                            else if (running_reg[idx_reg] && !taken_reg[idx_reg]
                                     && (!best_v_reg || q < best_q_reg))
                            begin
                                best_v_next = 1'b1;
                                best_idx_next = idx_reg;
                                best_key_next = rd_key;
                                best_q_next = q;
                            end
                        end
                    endcase
                    if (idx_reg == LAST_IDX)
                    begin
                        if (op_reg == FUNC_SET)
                        begin
                            state_next = ST_SETW;
                        end
                        else if (op_reg == FUNC_LIST && want_reg != '0)
                        begin
                            state_next = ST_PEND;
                        end
                        else
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                        state_next = ST_RD;
                    end
                end
            end
            ST_SETW:
            begin
                if (can_act)
                begin
                    wr.en = 1'b1;
                    wr.key = key_reg;
                    wr.ms = load_reg;
                    wr_addr = slot;
                    running_next[slot] = 1'b1;
                    emit = 1'b1;
                    emit_res = '{kind: KIND_SET, key: key_reg, secs: secs_reg,
                                 was: running_reg[slot], bad: 1'b0};
                    state_next = ST_FLUSH;
                end
            end
            ST_PEND:
            begin
                if (can_act)
                begin
                    if (best_v_reg)
                    begin
                        emit = 1'b1;
                        emit_res = '{kind: KIND_LIST, key: best_key_reg, secs: best_q_reg,
                                     was: 1'b0, bad: 1'b0};
                        taken_next[best_idx_reg] = 1'b1;
                        n_next = n_reg + CNT_W'(1);
                        best_v_next = 1'b0;
                        idx_next = '0;
                        state_next = (n_next == want_reg) ? ST_FLUSH : ST_RD;
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!h_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    push = 1'b1;
                    push_last = 1'b1;
                    h_valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            if (h_valid_reg)
            begin
                push = 1'b1;
            end
            h_valid_next = 1'b1;
            h_res_next = emit_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            running_reg <= '0;
            h_valid_reg <= 1'b0;
            taken_reg <= '0;
            found_reg <= 1'b0;
            best_v_reg <= 1'b0;
            n_reg <= '0;
            idx_reg <= '0;
            op_reg <= FUNC_NOP;
        end
        else
        begin
            state_reg <= state_next;
            running_reg <= running_next;
            h_valid_reg <= h_valid_next;
            taken_reg <= taken_next;
            found_reg <= found_next;
            best_v_reg <= best_v_next;
            n_reg <= n_next;
            idx_reg <= idx_next;
            op_reg <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        secs_reg <= secs_next;
        want_reg <= want_next;
        load_reg <= load_next;
        match_reg <= match_next;
        best_idx_reg <= best_idx_next;
        best_key_reg <= best_key_next;
        best_q_reg <= best_q_next;
        h_res_reg <= h_res_next;
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PROD_W'(rd_ms) * PROD_W'(RECIP);
        end
    end
endmodule

[hw/rtl/keyed_countdown_timer_table.sv]
// top level of the keyed countdown timer table with its output register
// One item at a time. A set, a tick and a list of all timers each scan every slot once; a
// zero key set is rejected without a scan. Listing the N nearest scans the slots once per
// result, with N cut to the number of running timers, plus one more scan when N was cut.
// Every slot is read from the slot memory, passed through the divide-by-1000 multiplier and
// then evaluated. Results stall the scan while the output register is full. Code 3 is taken
// and dropped.
`include "assert_macros.svh"
module keyed_countdown_timer_table
    import kctt_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       func,
    input  logic [KEY_W-1:0] key,
    input  logic [SEC_W-1:0] seconds,
    input  logic [CNT_W-1:0] list_count,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       kind,
    output logic [KEY_W-1:0] out_key,
    output logic [SEC_W-1:0] seconds_left,
    output logic             was_running,
    output logic             bad_key,
    output logic             last
);
    logic out_valid_reg, out_valid_next;
    res_t out_res_reg;
    logic out_last_reg;
    logic out_free, push, push_last;
    res_t push_res;

    assign out_free = !out_valid_reg || out_ready;

    kctt_ctrl #(.SLOT_COUNT(SLOT_COUNT)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .key        (key),
        .seconds    (seconds),
        .list_count (list_count),
        .out_free   (out_free),
        .push       (push),
        .push_res   (push_res),
        .push_last  (push_last)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_res_reg <= push_res;
            out_last_reg <= push_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind = out_res_reg.kind;
    assign out_key = out_res_reg.key;
    assign seconds_left = out_res_reg.secs;
    assign was_running = out_res_reg.was;
    assign bad_key = out_res_reg.bad;
    assign last = out_last_reg;

    `CHK_NEXT(a_busy_after_take, clk, rst_n,
        in_valid && in_ready && func != FUNC_NOP, !in_ready,
        "block still ready after taking an item")
    `CHK_IMPL(a_bad_key_alone, clk, rst_n,
        out_valid && bad_key, last && kind == KIND_SET,
        "rejected set not a lone set result")
    `CHK_IMPL(a_push_room, clk, rst_n, push, out_free,
        "result pushed into a full output register")
endmodule

[test/keyed_countdown_timer_table_test.sv]
// testbench: timer table driven by a directed table and random items, checked by a predictor
module keyed_countdown_timer_table_test;
    import kctt_pkg::*;

    localparam int SLOTS = 10;

    typedef struct {
        logic [1:0]       f;
        logic [KEY_W-1:0] k;
        logic [SEC_W-1:0] s;
        logic [CNT_W-1:0] n;
        bit               typed;
        res_t             r;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [1:0]       func;
    logic [KEY_W-1:0] key;
    logic [SEC_W-1:0] seconds;
    logic [CNT_W-1:0] list_count;
    logic             out_valid;
    logic             out_ready;
    logic [1:0]       kind;
    logic [KEY_W-1:0] out_key;
    logic [SEC_W-1:0] seconds_left;
    logic             was_running;
    logic             bad_key;
    logic             last;

    logic [KEY_W-1:0] timer_key [SLOTS];
    logic [MS_W-1:0]  timer_ms [SLOTS];
    bit               timer_on [SLOTS];

    res_t      pending_results [$];
    bit        pending_last [$];
    bit        failed;
    bit        calm;
    stim_row_t directed [$];

    keyed_countdown_timer_table uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .key(key), .seconds(seconds), .list_count(list_count),
        .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .out_key(out_key),
        .seconds_left(seconds_left), .was_running(was_running), .bad_key(bad_key),
        .last(last)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #80000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic res_t mk(logic [1:0] kd, logic [KEY_W-1:0] k, logic [SEC_W-1:0] s,
                                logic w, logic b);
        res_t r;
        r.kind = kd;
        r.key = k;
        r.secs = s;
        r.was = w;
        r.bad = b;
        return r;
    endfunction

    task automatic push_result(res_t r);
        pending_results.push_back(r);
        pending_last.push_back(0);
    endtask

    task automatic close_run(int base);
        if (pending_last.size() > base)
            pending_last[pending_last.size()-1] = 1;
    endtask

    task automatic predict_timers(logic [1:0] f, logic [KEY_W-1:0] k, logic [SEC_W-1:0] s,
                                  logic [CNT_W-1:0] n);
        int         base;
        int         slot;
        int         want;
        int         active;
        int         best;
        logic [31:0] bsec;
        logic [31:0] sec;
        bit         taken [SLOTS];
        logic [31:0] load;
        base = pending_results.size();
        if (f == FUNC_SET) begin
            if (k == 0)
                push_result(mk(KIND_SET, 0, 0, 0, 1));
            else begin
                slot = -1;
                for (int i = 0; i < SLOTS && slot < 0; i++)
                    if (timer_on[i] && timer_key[i] == k)
                        slot = i;
                for (int i = 0; i < SLOTS && slot < 0; i++)
                    if (!timer_on[i])
                        slot = i;
                if (slot < 0)
                    slot = 0;
                push_result(mk(KIND_SET, k, s, timer_on[slot], 0));
                load = s * 32'd1000;
                timer_key[slot] = k;
                timer_ms[slot] = load[MS_W-1:0];
                timer_on[slot] = 1;
            end
        end else if (f == FUNC_TICK) begin
            for (int i = 0; i < SLOTS; i++)
                if (timer_on[i]) begin
                    if (timer_ms[i] <= 1) begin
                        push_result(mk(KIND_EXPIRY, timer_key[i], 0, 0, 0));
                        timer_key[i] = 0;
                        timer_ms[i] = 0;
                        timer_on[i] = 0;
                    end else
                        timer_ms[i] = timer_ms[i] - MS_W'(1);
                end
        end else if (f == FUNC_LIST) begin
            if (n == 0) begin
                for (int i = 0; i < SLOTS; i++)
                    if (timer_on[i])
                        push_result(mk(KIND_LIST, timer_key[i],
                                       SEC_W'(timer_ms[i] / 1000), 0, 0));
            end else begin
                active = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    taken[i] = 0;
                    if (timer_on[i])
                        active++;
                end
                want = (n > active) ? active : n;
                for (int c = 0; c < want; c++) begin
                    best = -1;
                    bsec = 0;
                    for (int i = 0; i < SLOTS; i++)
                        if (timer_on[i] && !taken[i]) begin
                            sec = timer_ms[i] / 1000;
                            if (best < 0 || sec < bsec) begin
                                best = i;
                                bsec = sec;
                            end
                        end
                    taken[best] = 1;
                    push_result(mk(KIND_LIST, timer_key[best], bsec[SEC_W-1:0], 0, 0));
                end
            end
        end
        close_run(base);
    endtask

    task automatic send_item(logic [1:0] f, logic [KEY_W-1:0] k, logic [SEC_W-1:0] s,
                             logic [CNT_W-1:0] n);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        func <= f;
        key <= k;
        seconds <= s;
        list_count <= n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_timers(f, k, s, n);
    endtask

    // receiver with random stall bursts
    initial
    begin
        int stall;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 4) == 0) begin
                out_ready <= 0;
                stall = $urandom_range(1, 18);
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected item kind=%0d key=%0h", kind, out_key);
                    failed = 1;
                end else begin
                    res_t e;
                    bit el;
                    e = pending_results.pop_front();
                    el = pending_last.pop_front();
                    if (kind !== e.kind) begin
                        $error("kind expected %0d actual %0d", e.kind, kind);
                        failed = 1;
                    end
                    if (out_key !== e.key) begin
                        $error("out_key expected %0h actual %0h", e.key, out_key);
                        failed = 1;
                    end
                    if (seconds_left !== e.secs) begin
                        $error("seconds_left expected %0d actual %0d", e.secs, seconds_left);
                        failed = 1;
                    end
                    if (was_running !== e.was) begin
                        $error("was_running expected %0b actual %0b", e.was, was_running);
                        failed = 1;
                    end
                    if (bad_key !== e.bad) begin
                        $error("bad_key expected %0b actual %0b", e.bad, bad_key);
                        failed = 1;
                    end
                    if (last !== el) begin
                        $error("last expected %0b actual %0b", el, last);
                        failed = 1;
                    end
                end
            end
        end
    end

    task automatic add_row(logic [1:0] f, logic [KEY_W-1:0] k, logic [SEC_W-1:0] s,
                           logic [CNT_W-1:0] n, bit t, res_t r);
        stim_row_t row;
        row.f = f;
        row.k = k;
        row.s = s;
        row.n = n;
        row.typed = t;
        row.r = r;
        directed.push_back(row);
    endtask

    initial
    begin
        int      pick;
        int      wait_cycles;
        logic [1:0] f;
        res_t    none;
        none = mk(0, 0, 0, 0, 0);
        failed = 0;
        calm = 0;
        rst_n = 0;
        in_valid = 0;
        func = FUNC_SET;
        key = 0;
        seconds = 0;
        list_count = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            timer_key[i] = 0;
            timer_ms[i] = 0;
            timer_on[i] = 0;
        end

        add_row(FUNC_LIST, 0, 0, 0, 0, none);
        add_row(FUNC_TICK, 0, 0, 0, 0, none);
        add_row(FUNC_SET, 16'h0000, 16'hFFFF, 4'hF, 1, mk(KIND_SET, 0, 0, 0, 1));
        add_row(FUNC_SET, 16'hFFFF, 16'hFFFF, 0, 1, mk(KIND_SET, 16'hFFFF, 16'hFFFF, 0, 0));
        add_row(FUNC_SET, 16'h0001, 16'h0000, 0, 1, mk(KIND_SET, 16'h0001, 0, 0, 0));
        add_row(FUNC_SET, 16'h0001, 16'h0002, 0, 1, mk(KIND_SET, 16'h0001, 2, 1, 0));
        add_row(FUNC_SET, 16'h5555, 16'h0000, 0, 0, none);
        add_row(FUNC_TICK, 16'hFFFF, 16'hFFFF, 4'hF, 0, none);
        add_row(FUNC_NOP, 16'hAAAA, 16'h5555, 4'hA, 0, none);
        add_row(FUNC_SET, 16'hAAAA, 16'h0001, 0, 0, none);
        add_row(FUNC_SET, 16'h0003, 16'h0001, 0, 0, none);
        for (int i = 0; i < 7; i++)
            add_row(FUNC_SET, 16'(16'h0100 + i), 16'd70 - 16'(i * 9), 0, 0, none);
        add_row(FUNC_SET, 16'h7777, 16'h0005, 0, 0, none);
        add_row(FUNC_LIST, 0, 0, 4'd0, 0, none);
        add_row(FUNC_LIST, 0, 0, 4'd1, 0, none);
        add_row(FUNC_LIST, 0, 0, 4'd10, 0, none);
        add_row(FUNC_LIST, 0, 0, 4'd15, 0, none);
        add_row(FUNC_LIST, 16'hFFFF, 16'hFFFF, 4'd5, 0, none);

        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_item(directed[i].f, directed[i].k, directed[i].s, directed[i].n);
            if (directed[i].typed && pending_results.size() > 0
                && pending_results[pending_results.size()-1] != directed[i].r) begin
                $error("prediction for row %0d differs from table", i);
                failed = 1;
            end
        end

        // random part: mostly sets of small keys and ticks, some lists and noise
        for (int i = 0; i < 128; i++)
        begin
            if (i >= 100)
                calm = 1;
            pick = $urandom_range(0, 99);
            if (pick < 40)
                f = FUNC_SET;
            else if (pick < 75)
                f = FUNC_TICK;
            else if (pick < 95)
                f = FUNC_LIST;
            else
                f = FUNC_NOP;
            send_item(f,
                      ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 14)),
                      ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2)),
                      4'($urandom));
        end
        in_valid <= 0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (400) @(posedge clk);
        if (!failed && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
